@@ rtl/tilt_atan_pkg.sv @@
// Shared types, widths and constants for the accelerometer tilt-angle unit.
// No dependencies; every other file of the block refers to this package.
package tilt_atan_pkg;

	localparam int SAMPLE_W           = 16;
	localparam int ANGLE_W            = 16;
	localparam int VEC_W              = 40;   // vector components, 20 fraction bits
	localparam int ACC_W              = 32;   // centidegrees with 16 fraction bits
	localparam int PRE_SHIFT          = 20;
	localparam int FRAC_W             = 16;
	localparam int HALF_TURN_CD       = 18000;
	localparam int ANGLE_TABLE_LEN    = 24;
	localparam int ROTATION_STEPS_DEF = 16;
	localparam int RES_W              = 19;   // rounded angle plus half-turn base

	// atan(2^-i) in centidegrees times 65536, rounded to nearest
	localparam logic signed [ACC_W-1:0] ATAN_TABLE [ANGLE_TABLE_LEN] = '{
		32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
		32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
		32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
		32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
		32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
		32'sd358,       32'sd179,       32'sd90,       32'sd45
	};

	// half turn added back after the rotations
	typedef enum logic [1:0] {
		BASE_ZERO,
		BASE_POS,
		BASE_NEG
	} base_t;

	// one item in flight through the row of cells
	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [ACC_W-1:0] acc;
		logic                    special;  // X was zero: result is the base alone
		base_t                   base;
	} cordic_t;

endpackage

@@ rtl/tilt_atan_in_if.sv @@
// Sample channel of the tilt-angle unit: valid/ready plus both axis counts.
// Depends on tilt_atan_pkg for field widths.
interface tilt_atan_in_if;
	logic                                         valid;
	logic                                         ready;
	logic signed [tilt_atan_pkg::SAMPLE_W-1:0]    accel_x;
	logic signed [tilt_atan_pkg::SAMPLE_W-1:0]    accel_z;

	modport source (output valid, output accel_x, output accel_z, input ready);
	modport sink   (input valid, input accel_x, input accel_z, output ready);
endinterface

@@ rtl/tilt_atan_out_if.sv @@
// Angle channel of the tilt-angle unit: valid/ready plus the angle in centidegrees.
// Depends on tilt_atan_pkg for the field width.
interface tilt_atan_out_if;
	logic                                        valid;
	logic                                        ready;
	logic signed [tilt_atan_pkg::ANGLE_W-1:0]    tilt_centideg;

	modport source (output valid, output tilt_centideg, input ready);
	modport sink   (input valid, input tilt_centideg, output ready);
endinterface

@@ rtl/tilt_atan_pre.sv @@
// Entry stage: special cases, half-turn fold into the right half-plane, pre-scale.
// Depends on tilt_atan_pkg and tilt_atan_in_if.
module tilt_atan_pre (
	input  logic                     clk,
	input  logic                     arst_n,
	tilt_atan_in_if.sink             sample,
	output logic                     down_valid,
	output tilt_atan_pkg::cordic_t   down_data,
	input  logic                     down_ready
);

	logic                            valid_q;
	tilt_atan_pkg::cordic_t          data_q;
	tilt_atan_pkg::cordic_t          prep;
	logic signed [tilt_atan_pkg::VEC_W-1:0] x_ext;
	logic signed [tilt_atan_pkg::VEC_W-1:0] nz_ext;
	logic                            load;

	assign sample.ready = !valid_q || down_ready;
	assign load         = sample.valid && sample.ready;

	always_comb begin
		x_ext          = tilt_atan_pkg::VEC_W'(sample.accel_x);
		nz_ext         = -tilt_atan_pkg::VEC_W'(sample.accel_z);
		prep.special   = 1'b0;
		prep.base      = tilt_atan_pkg::BASE_ZERO;
		prep.acc       = '0;
		prep.vx        = nz_ext;
		prep.vy        = x_ext;
		if (sample.accel_x == '0) begin
			prep.special = 1'b1;
			prep.base    = sample.accel_z[tilt_atan_pkg::SAMPLE_W-1] ?
				tilt_atan_pkg::BASE_ZERO : tilt_atan_pkg::BASE_POS;
			prep.vx      = '0;
			prep.vy      = '0;
		end else if (nz_ext[tilt_atan_pkg::VEC_W-1]) begin
			// left half-plane: turn by half a revolution
			prep.base = sample.accel_x[tilt_atan_pkg::SAMPLE_W-1] ?
				tilt_atan_pkg::BASE_NEG : tilt_atan_pkg::BASE_POS;
			prep.vx   = -nz_ext;
			prep.vy   = -x_ext;
		end
		prep.vx = prep.vx <<< tilt_atan_pkg::PRE_SHIFT;
		prep.vy = prep.vy <<< tilt_atan_pkg::PRE_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sample.ready) begin
			valid_q <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= prep;
		end
	end

	assign down_valid = valid_q;
	assign down_data  = data_q;

endmodule

@@ rtl/tilt_atan_cell.sv @@
// One vectoring micro-rotation with its own register; STEP fixes shift and angle.
// Depends on tilt_atan_pkg.
module tilt_atan_cell #(
	parameter int STEP = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	input  tilt_atan_pkg::cordic_t   up_data,
	output logic                     up_ready,
	output logic                     down_valid,
	output tilt_atan_pkg::cordic_t   down_data,
	input  logic                     down_ready
);

	localparam logic [tilt_atan_pkg::VEC_W-1:0] LOW_MASK =
		(tilt_atan_pkg::VEC_W'(1) << STEP) - tilt_atan_pkg::VEC_W'(1);

	logic                                   valid_q;
	tilt_atan_pkg::cordic_t                 data_q;
	tilt_atan_pkg::cordic_t                 rot;
	logic signed [tilt_atan_pkg::VEC_W-1:0] dx;
	logic signed [tilt_atan_pkg::VEC_W-1:0] dy;

	// arithmetic shifts round toward minus infinity: bump a negative value that lost set bits so it truncates toward zero
	assign dx = (up_data.vy >>> STEP) + $signed(tilt_atan_pkg::VEC_W'(
		up_data.vy[tilt_atan_pkg::VEC_W-1] && ((up_data.vy & LOW_MASK) != '0)));
	assign dy = (up_data.vx >>> STEP) + $signed(tilt_atan_pkg::VEC_W'(
		up_data.vx[tilt_atan_pkg::VEC_W-1] && ((up_data.vx & LOW_MASK) != '0)));

	always_comb begin
		rot = up_data;
		if (!up_data.vy[tilt_atan_pkg::VEC_W-1]) begin
			rot.vx  = up_data.vx + dx;
			rot.vy  = up_data.vy - dy;
			rot.acc = up_data.acc + tilt_atan_pkg::ATAN_TABLE[STEP];
		end else begin
			rot.vx  = up_data.vx - dx;
			rot.vy  = up_data.vy + dy;
			rot.acc = up_data.acc - tilt_atan_pkg::ATAN_TABLE[STEP];
		end
	end

	assign up_ready = !valid_q || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= rot;
		end
	end

	assign down_valid = valid_q;
	assign down_data  = data_q;

endmodule

@@ rtl/tilt_atan_post.sv @@
// Exit stage: round to centidegrees, add the half turn, clamp, output register.
// Depends on tilt_atan_pkg and tilt_atan_out_if.
module tilt_atan_post (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	input  tilt_atan_pkg::cordic_t   up_data,
	output logic                     up_ready,
	tilt_atan_out_if.source          angle
);

	localparam int MAG_W = tilt_atan_pkg::ACC_W + 1;
	localparam int RND_W = MAG_W - tilt_atan_pkg::FRAC_W;

	localparam logic signed [tilt_atan_pkg::RES_W-1:0] HALF_TURN =
		tilt_atan_pkg::RES_W'(tilt_atan_pkg::HALF_TURN_CD);
	localparam logic signed [tilt_atan_pkg::RES_W-1:0] LOW_LIMIT =
		-tilt_atan_pkg::RES_W'(tilt_atan_pkg::HALF_TURN_CD - 1);

	logic                                    valid_q;
	logic signed [tilt_atan_pkg::ANGLE_W-1:0] angle_q;
	logic                                    neg;
	logic [MAG_W-1:0]                        mag;
	logic [MAG_W-1:0]                        mag_rnd;
	logic signed [tilt_atan_pkg::RES_W-1:0]  rounded;
	logic signed [tilt_atan_pkg::RES_W-1:0]  base_val;
	logic signed [tilt_atan_pkg::RES_W-1:0]  total;
	logic signed [tilt_atan_pkg::RES_W-1:0]  clamped;

	always_comb begin
		neg     = up_data.acc[tilt_atan_pkg::ACC_W-1];
		mag     = neg ? MAG_W'(-up_data.acc) : MAG_W'(up_data.acc);
		// ties away from zero on the magnitude
		mag_rnd = (mag + (MAG_W'(1) << (tilt_atan_pkg::FRAC_W - 1))) >> tilt_atan_pkg::FRAC_W;
		rounded = tilt_atan_pkg::RES_W'(mag_rnd[RND_W-1:0]);
		if (neg) begin
			rounded = -rounded;
		end
		case (up_data.base)
			tilt_atan_pkg::BASE_ZERO: base_val = '0;
			tilt_atan_pkg::BASE_POS:  base_val = HALF_TURN;
			tilt_atan_pkg::BASE_NEG:  base_val = -HALF_TURN;
			default:                  base_val = '0;
		endcase
		total   = up_data.special ? base_val : rounded + base_val;
		clamped = total;
		if (total < LOW_LIMIT) begin
			clamped = LOW_LIMIT;
		end else if (total > HALF_TURN) begin
			clamped = HALF_TURN;
		end
	end

	assign up_ready = !valid_q || angle.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			angle_q <= clamped[tilt_atan_pkg::ANGLE_W-1:0];
		end
	end

	assign angle.valid         = valid_q;
	assign angle.tilt_centideg = angle_q;

endmodule

@@ rtl/accel_tilt_angle_atan2_unit.sv @@
// Top level of the accelerometer tilt-angle unit: atan2(x, -z) in centidegrees.
// Depends on tilt_atan_pkg, both channel interfaces, tilt_atan_pre/_cell/_post.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+--------------------------------------------
//   sample  | in  | valid/ready  | accel_x s16, accel_z s16 (raw counts)
//   angle   | out | valid/ready  | tilt_centideg s16, -17999 .. 18000
//
// One item a cycle enters and leaves while the angle sink stays ready; each item
// passes the entry stage, one cell per micro-rotation and the output register.
// Each stage has its own valid flag and holds while the stage after it is full,
// so a stalled output fills the gaps behind it before sample.ready drops.
// Reset clears every valid flag; the payload registers are left as they are.
module accel_tilt_angle_atan2_unit #(
	parameter int ROTATION_STEPS = tilt_atan_pkg::ROTATION_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	tilt_atan_in_if.sink     sample,
	tilt_atan_out_if.source  angle
);

	// steps beyond the angle table are not performed
	localparam int NUM_CELLS = (ROTATION_STEPS > tilt_atan_pkg::ANGLE_TABLE_LEN) ?
		tilt_atan_pkg::ANGLE_TABLE_LEN : ROTATION_STEPS;

	// link k feeds cell k; link NUM_CELLS feeds the output stage
	tilt_atan_pkg::cordic_t  link_data  [NUM_CELLS+1];
	logic                    link_valid [NUM_CELLS+1];
	logic                    link_ready [NUM_CELLS+1];

	// fold, special cases and pre-scale
	tilt_atan_pre u_pre (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.down_valid (link_valid[0]),
		.down_data  (link_data[0]),
		.down_ready (link_ready[0])
	);

	// row of micro-rotations, each drives Y towards zero by atan(2^-k)
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		tilt_atan_cell #(
			.STEP (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (link_valid[k]),
			.up_data    (link_data[k]),
			.up_ready   (link_ready[k]),
			.down_valid (link_valid[k+1]),
			.down_data  (link_data[k+1]),
			.down_ready (link_ready[k+1])
		);
	end

	// round, add the half turn back, clamp and hold for the sink
	tilt_atan_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (link_valid[NUM_CELLS]),
		.up_data  (link_data[NUM_CELLS]),
		.up_ready (link_ready[NUM_CELLS]),
		.angle    (angle)
	);

endmodule

@@ rtl/tilt_atan_chk.sv @@
// Port-level checker for the tilt-angle unit, attached to the top level by bind.
// Depends on tilt_atan_pkg and the top level accel_tilt_angle_atan2_unit.
module tilt_atan_chk #(
	parameter int DEPTH = tilt_atan_pkg::ROTATION_STEPS_DEF + 2
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic                                     in_ready,
	input  logic                                     out_valid,
	input  logic                                     out_ready,
	input  logic signed [tilt_atan_pkg::ANGLE_W-1:0] out_angle
);

	localparam int CNT_W = $clog2(DEPTH + 1) + 1;

	logic [CNT_W-1:0] inflight_q;
	logic             in_fire;
	logic             out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_fire && !out_fire) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_fire && !in_fire) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	// a stalled angle holds its value
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_angle))
		else $error("angle changed or dropped while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_angle >= -16'sd17999) && (out_angle <= 16'sd18000))
		else $error("angle outside (-180, 180] degrees");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("angle shown with no item in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(DEPTH))
		else $error("more items in flight than pipeline stages");

endmodule

bind accel_tilt_angle_atan2_unit tilt_atan_chk #(
	.DEPTH (NUM_CELLS + 2)
) u_tilt_atan_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (angle.valid),
	.out_ready (angle.ready),
	.out_angle (angle.tilt_centideg)
);

@@ verif/tilt_angle_checker.sv @@
`timescale 1ns / 100ps
// Checker for the tilt-angle unit: watches the sample and angle channels,
// predicts each angle and compares it in order. Depends on tilt_atan_pkg
// and both channel interfaces.
module tilt_angle_checker #(
	parameter int STEPS = tilt_atan_pkg::ROTATION_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tilt_atan_in_if   sample,
	tilt_atan_out_if  angle,
	output int        fail_count,
	output int        outstanding,
	output int        sample_count,
	output int        angle_count
);

	logic signed [tilt_atan_pkg::ANGLE_W-1:0] expected_angles [$];
	logic signed [tilt_atan_pkg::ANGLE_W-1:0] want;

	function automatic longint shift_toward_zero(input longint v, input int s);
		return (v < 0) ? -((-v) >>> s) : (v >>> s);
	endfunction

	// atan2(x, -z) in centidegrees through a vectoring rotation with STEPS steps, at most the angle table length
	function automatic logic signed [tilt_atan_pkg::ANGLE_W-1:0] tilt_from_axes(
		input logic signed [tilt_atan_pkg::SAMPLE_W-1:0] ax,
		input logic signed [tilt_atan_pkg::SAMPLE_W-1:0] az
	);
		longint vx, vy, acc, dx, dy, rnd, base;
		int     n;
		if (ax == 0)
			return (az < 0) ? tilt_atan_pkg::ANGLE_W'(0) :
				tilt_atan_pkg::ANGLE_W'(tilt_atan_pkg::HALF_TURN_CD);
		vx   = -longint'(az);
		vy   = longint'(ax);
		base = 0;
		if (vx < 0) begin
			base = (vy >= 0) ? tilt_atan_pkg::HALF_TURN_CD : -tilt_atan_pkg::HALF_TURN_CD;
			vx   = -vx;
			vy   = -vy;
		end
		vx  = vx <<< tilt_atan_pkg::PRE_SHIFT;
		vy  = vy <<< tilt_atan_pkg::PRE_SHIFT;
		acc = 0;
		n   = (STEPS > tilt_atan_pkg::ANGLE_TABLE_LEN) ? tilt_atan_pkg::ANGLE_TABLE_LEN : STEPS;
		for (int i = 0; i < n; i++) begin
			dx = shift_toward_zero(vy, i);
			dy = shift_toward_zero(vx, i);
			if (vy >= 0) begin
				vx  = vx + dx;
				vy  = vy - dy;
				acc = acc + longint'(tilt_atan_pkg::ATAN_TABLE[i]);
			end else begin
				vx  = vx - dx;
				vy  = vy + dy;
				acc = acc - longint'(tilt_atan_pkg::ATAN_TABLE[i]);
			end
		end
		if (acc < 0)
			rnd = -((-acc + 32768) >>> tilt_atan_pkg::FRAC_W);
		else
			rnd = (acc + 32768) >>> tilt_atan_pkg::FRAC_W;
		rnd = rnd + base;
		if (rnd < -(tilt_atan_pkg::HALF_TURN_CD - 1))
			rnd = -(tilt_atan_pkg::HALF_TURN_CD - 1);
		if (rnd > tilt_atan_pkg::HALF_TURN_CD)
			rnd = tilt_atan_pkg::HALF_TURN_CD;
		return tilt_atan_pkg::ANGLE_W'(rnd);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_angles.delete();
			fail_count   <= 0;
			outstanding  <= 0;
			sample_count <= 0;
			angle_count  <= 0;
		end else begin
			if (angle.valid && angle.ready) begin
				angle_count <= angle_count + 1;
				if (expected_angles.size() == 0) begin
					$display("%0t: unexpected angle %0d, none pending", $time,
						angle.tilt_centideg);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_angles.pop_front();
					if (angle.tilt_centideg !== want) begin
						$display("%0t: tilt_centideg mismatch, expected %0d actual %0d",
							$time, want, angle.tilt_centideg);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (sample.valid && sample.ready) begin
				expected_angles.push_back(tilt_from_axes(sample.accel_x, sample.accel_z));
				sample_count <= sample_count + 1;
			end
			outstanding <= expected_angles.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the tilt-angle testbench: clock, reset, sample stimulus and angle
// back-pressure. Depends on tilt_atan_pkg, both channel interfaces, the unit
// and tilt_angle_checker, which does all prediction and comparison.
module tb_top;

	localparam int STEPS       = tilt_atan_pkg::ROTATION_STEPS_DEF;
	localparam int HOLD_CYCLES = 96;       // well beyond the pipeline depth
	localparam int CYCLE_LIMIT = 100000;
	localparam logic signed [tilt_atan_pkg::SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [tilt_atan_pkg::SAMPLE_W-1:0] S_MIN = 16'sh8000;

	logic clk;
	logic arst_n;

	tilt_atan_in_if  sample ();
	tilt_atan_out_if angle ();

	int  fail_count, outstanding, sample_count, angle_count;
	int  cycle_count = 0;
	int  hold_asks   = 0;   // bumped by the sender to request a long output stall
	bit  src_gaps    = 1'b1;
	bit  sink_gaps   = 1'b1;

	accel_tilt_angle_atan2_unit #(.ROTATION_STEPS(STEPS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.angle  (angle)
	);

	tilt_angle_checker #(.STEPS(STEPS)) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.angle        (angle),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.sample_count (sample_count),
		.angle_count  (angle_count)
	);

	// 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Give up if the run hangs: a lost angle or a stuck handshake ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Angle receiver. Drop ready at random while gaps are enabled; on request,
	// hold it low for a long stretch so the pipeline fills and sample.ready falls.
	initial begin
		int hold_left;
		int hold_served;
		hold_left   = 0;
		hold_served = 0;
		angle.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				angle.ready <= 1'b0;
				hold_left   = hold_left - 1;
			end else if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				hold_left   = HOLD_CYCLES - 1;
				angle.ready <= 1'b0;
			end else begin
				angle.ready <= !sink_gaps || ($urandom_range(0, 99) >= 21);
			end
		end
	end

	// Offer one sample and hold it until the unit takes it. Idle cycles go in
	// front of the item, so gaps land on every stage of the pipeline.
	task automatic send_sample(input logic signed [tilt_atan_pkg::SAMPLE_W-1:0] x,
			input logic signed [tilt_atan_pkg::SAMPLE_W-1:0] z);
		while (src_gaps && $urandom_range(0, 99) < 21) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid   <= 1'b1;
		sample.accel_x <= x;
		sample.accel_z <= z;
		do
			@(posedge clk);
		while (!sample.ready);
	endtask

	// Stop offering and wait for every predicted angle to come back.
	task automatic drain_angles();
		sample.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	function automatic logic signed [tilt_atan_pkg::SAMPLE_W-1:0] extreme_count();
		case ($urandom_range(0, 4))
			0:       return S_MIN;
			1:       return -16'sd1;
			2:       return 16'sd0;
			3:       return 16'sd1;
			default: return S_MAX;
		endcase
	endfunction

	// Random sample with a bias towards the axes, the corners and the
	// near-half-turn region, where the rounding and clamping live.
	task automatic random_sample(output logic signed [tilt_atan_pkg::SAMPLE_W-1:0] x,
			output logic signed [tilt_atan_pkg::SAMPLE_W-1:0] z);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				x = tilt_atan_pkg::SAMPLE_W'($urandom);
				z = tilt_atan_pkg::SAMPLE_W'($urandom);
			end
			4, 5: begin
				x = tilt_atan_pkg::SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
				z = tilt_atan_pkg::SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
			end
			6: begin
				x = '0;
				z = tilt_atan_pkg::SAMPLE_W'($urandom);
			end
			7: begin
				x = tilt_atan_pkg::SAMPLE_W'($urandom);
				z = tilt_atan_pkg::SAMPLE_W'(int'($urandom_range(0, 2)) - 1);
			end
			8: begin
				x = extreme_count();
				z = extreme_count();
			end
			default: begin
				// tiny X against a large Z: angles just off 0 or just off the half turn
				x = tilt_atan_pkg::SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
				z = tilt_atan_pkg::SAMPLE_W'($urandom);
			end
		endcase
	endtask

	task automatic random_burst(input int count, input int hold_at);
		logic signed [tilt_atan_pkg::SAMPLE_W-1:0] x, z;
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_asks <= hold_asks + 1;
			random_sample(x, z);
			send_sample(x, z);
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		sample.valid   <= 1'b0;
		sample.accel_x <= '0;
		sample.accel_z <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: both X-zero cases, field extremes, all four quadrants,
		// and the values either side of the half turn.
		send_sample(16'sd0, -16'sd1);       // X zero, Z negative: 0
		send_sample(16'sd0, S_MIN);
		send_sample(16'sd0, 16'sd0);        // X zero, Z zero: +180
		send_sample(16'sd0, 16'sd1);
		send_sample(16'sd0, S_MAX);
		send_sample(S_MAX, S_MAX);
		send_sample(S_MIN, S_MIN);
		send_sample(S_MAX, S_MIN);
		send_sample(S_MIN, S_MAX);
		send_sample(S_MAX, 16'sd0);
		send_sample(S_MIN, 16'sd0);
		send_sample(16'sd1, 16'sd0);
		send_sample(-16'sd1, 16'sd0);
		send_sample(16'sd1, S_MIN);         // just above 0
		send_sample(-16'sd1, S_MIN);        // just below 0
		send_sample(16'sd1, S_MAX);         // rounds up to +180
		send_sample(-16'sd1, S_MAX);        // would round to -180: clamped
		send_sample(-16'sd1, S_MIN);
		send_sample(16'sd100, -16'sd100);   // 45 degrees
		send_sample(-16'sd100, 16'sd100);   // -135 degrees
		send_sample(16'sd100, 16'sd100);    // 135 degrees
		send_sample(-16'sd1, -16'sd1);
		drain_angles();

		// Random with gaps on both sides; a long output stall part way in.
		random_burst(180, 60);
		drain_angles();

		// Long stretch at full rate on both sides.
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		random_burst(170, -1);

		// Gaps back on for the tail, with a second long stall.
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		random_burst(180, 120);
		drain_angles();

		// Let any stray angle surface before the verdict.
		repeat (STEPS + 12) @(posedge clk);

		$display("Run covered %0d samples (axis, corner, half-turn and random cases,",
			sample_count);
		$display("two long output stalls, full-rate stretch) and %0d angles compared.",
			angle_count);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
